// File: src/kmd_pkg.sv
// Shared constants, types and the per-key debounce step for the keypad debouncer.
package kmd_pkg;

  localparam int ROWS  = 4;
  localparam int COLS  = 3;
  localparam int NKEYS = ROWS * COLS;

  localparam int ROW_W  = 2;
  localparam int COL_W  = 3;
  localparam int CODE_W = 4;

  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

  typedef enum logic [1:0] {
    ST_RELEASED     = 2'd0,
    ST_PRE_PRESSED  = 2'd1,
    ST_PRESSED      = 2'd2,
    ST_PRE_RELEASED = 2'd3
  } deb_state_e;

  // Bit 1 of the history is the older sample, bit 0 the newer one.
  function automatic deb_state_e next_state(deb_state_e st, logic [1:0] hist);
    logic both_pressed;
    logic both_released;
    deb_state_e nxt;
    both_pressed  = (hist[1] == LVL_PRESSED) && (hist[0] == LVL_PRESSED);
    both_released = (hist[1] == LVL_RELEASED) && (hist[0] == LVL_RELEASED);
    case (st)
      ST_RELEASED:     nxt = both_pressed ? ST_PRE_PRESSED : ST_RELEASED;
      ST_PRE_PRESSED:  nxt = both_pressed ? ST_PRESSED : ST_PRE_PRESSED;
      ST_PRESSED:      nxt = both_released ? ST_PRE_RELEASED : ST_PRESSED;
      ST_PRE_RELEASED: nxt = both_released ? ST_RELEASED : ST_PRE_RELEASED;
      default:         nxt = ST_RELEASED;
    endcase
    return nxt;
  endfunction

endpackage

// File: src/keypad_matrix_debounce_top.sv
// Keypad row debouncer: per-key sample history, debounce machines and key-code encoder.
// Path: a row item accepted into the input register updates the debounce machines and
// has its key code written to the result register, from which it is then taken.
// Throughput: one row item per cycle; the input register and the result register
// both advance together whenever the result register is empty or being taken.
// Reset: all keys released with both history samples at the released level,
// no item in flight.
module keypad_matrix_debounce_top
  import kmd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ROW_W-1:0]  row_index_i,
  input  logic [COL_W-1:0]  column_levels_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CODE_W-1:0] key_code_o
);

  logic              stage_valid_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  levels_q;
  logic              out_valid_q;
  logic [CODE_W-1:0] code_q;
  logic [CODE_W-1:0] code_d;

  logic [1:0] hist_q [NKEYS];
  logic [1:0] hist_d [NKEYS];
  deb_state_e st_q [NKEYS];
  deb_state_e st_d [NKEYS];

  logic            out_free;
  logic            advance;
  logic            in_take;
  logic [COLS-1:0] lvl_w;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = stage_valid_q && out_free;
  assign in_stall_o = stage_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Columns above the input field read as the pressed level (zero).
  assign lvl_w = COLS'(levels_q);

  always_comb begin
    code_d = '0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        hist_d[r*COLS+c] = hist_q[r*COLS+c];
        st_d[r*COLS+c]   = st_q[r*COLS+c];
        if (int'(row_q) == r) begin
          hist_d[r*COLS+c] = {hist_q[r*COLS+c][0], lvl_w[c]};
          st_d[r*COLS+c]   = next_state(st_q[r*COLS+c], hist_d[r*COLS+c]);
        end
      end
    end
    // The highest-numbered pre-released key wins.
    for (int k = 0; k < NKEYS; k++) begin
      if (st_d[k] == ST_PRE_RELEASED) begin
        code_d = CODE_W'(k + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      for (int k = 0; k < NKEYS; k++) begin
        hist_q[k] <= {LVL_RELEASED, LVL_RELEASED};
        st_q[k]   <= ST_RELEASED;
      end
    end else begin
      if (out_free) begin
        out_valid_q <= stage_valid_q;
      end
      if (!in_stall_o) begin
        stage_valid_q <= in_valid_i;
      end
      if (advance) begin
        for (int k = 0; k < NKEYS; k++) begin
          hist_q[k] <= hist_d[k];
          st_q[k]   <= st_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      row_q    <= row_index_i;
      levels_q <= column_levels_i;
    end
    if (advance) begin
      code_q <= code_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_code_o  = code_q;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && stage_valid_q))
    else $error("input stalled while the result register could move");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid_q && !out_free) |=> stage_valid_q)
    else $error("item in the input register lost while blocked");

  a_code_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((NKEYS > 15) || (int'(key_code_o) <= NKEYS)))
    else $error("key code beyond the number of keys");

endmodule
